// File: design/i2cras_pkg.sv
// Shared types and codes for the I2C register access sequencer.
// Holds request/result structs, engine status codes, bus actions and phase codes.
// No dependencies.
package i2cras_pkg;

    // Engine status codes, after the low three bits are masked off.
    localparam logic [7:0] ST_MASK       = 8'hF8;
    localparam logic [7:0] ST_START      = 8'h08;
    localparam logic [7:0] ST_REP_START  = 8'h10;
    localparam logic [7:0] ST_SLAW_ACK   = 8'h18;
    localparam logic [7:0] ST_SLAW_NACK  = 8'h20;
    localparam logic [7:0] ST_WDATA_ACK  = 8'h28;
    localparam logic [7:0] ST_ARB_LOST   = 8'h38;
    localparam logic [7:0] ST_SLAR_ACK   = 8'h40;
    localparam logic [7:0] ST_SLAR_NACK  = 8'h48;
    localparam logic [7:0] ST_RDATA_NACK = 8'h58;

    // Bus actions requested from the byte engine.
    localparam logic [1:0] ACT_START = 2'd0;
    localparam logic [1:0] ACT_SEND  = 2'd1;
    localparam logic [1:0] ACT_RECV  = 2'd2;
    localparam logic [1:0] ACT_STOP  = 2'd3;

    // Request kinds.
    localparam logic FUNC_COMMAND = 1'b0;
    localparam logic FUNC_STATUS  = 1'b1;

    // Sequencer phases.
    localparam int unsigned PHASE_W = 3;
    localparam logic [PHASE_W-1:0] PH_IDLE   = 3'd0;
    localparam logic [PHASE_W-1:0] PH_START  = 3'd1;
    localparam logic [PHASE_W-1:0] PH_SLAW   = 3'd2;
    localparam logic [PHASE_W-1:0] PH_REG    = 3'd3;
    localparam logic [PHASE_W-1:0] PH_DATA   = 3'd4;
    localparam logic [PHASE_W-1:0] PH_RSTART = 3'd5;
    localparam logic [PHASE_W-1:0] PH_SLAR   = 3'd6;
    localparam logic [PHASE_W-1:0] PH_RX     = 3'd7;

    typedef logic [PHASE_W-1:0] phase_t;

    typedef struct packed {
        logic       func;
        logic       is_read;
        logic [6:0] target_addr;
        logic [7:0] reg_addr;
        logic [7:0] write_data;
        logic [7:0] status;
        logic [7:0] rx_byte;
    } in_t;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] tx_byte;
        logic       done_res;
        logic       success;
        logic [7:0] read_data;
    } out_t;

    // Transfer context held from the command for the whole transfer.
    typedef struct packed {
        logic       op_read;
        logic [6:0] device;
        logic [7:0] register;
        logic [7:0] wdata;
    } ctx_t;

endpackage

// File: design/i2cras_decode.sv
// Next-action decision of the I2C register access sequencer.
// Pure combinational logic from phase, held context and one request.
// Depends on i2cras_pkg.
module i2cras_decode (
    input  i2cras_pkg::phase_t phase,
    input  i2cras_pkg::ctx_t   ctx,
    input  i2cras_pkg::in_t    req,
    output logic               res_valid,
    output i2cras_pkg::out_t   res,
    output i2cras_pkg::phase_t phase_next,
    output i2cras_pkg::ctx_t   ctx_next
);

    logic [7:0] st;
    logic       busy;
    logic       is_start;

    assign st       = req.status & i2cras_pkg::ST_MASK;
    assign busy     = (phase != i2cras_pkg::PH_IDLE);
    assign is_start = (st == i2cras_pkg::ST_START) || (st == i2cras_pkg::ST_REP_START);

    always_comb begin
        res_valid  = 1'b0;
        res        = '0;
        phase_next = phase;
        ctx_next   = ctx;

        if (req.func == i2cras_pkg::FUNC_COMMAND) begin
            if (!busy) begin
                ctx_next.op_read  = req.is_read;
                ctx_next.device   = req.target_addr;
                ctx_next.register = req.reg_addr;
                ctx_next.wdata    = req.write_data;
                res_valid         = 1'b1;
                res.action        = i2cras_pkg::ACT_START;
                phase_next        = i2cras_pkg::PH_START;
            end
        end else if (busy) begin
            res_valid = 1'b1;
            // Failure stop unless an arm below says otherwise.
            res.action    = i2cras_pkg::ACT_STOP;
            res.done_res  = 1'b1;
            phase_next    = i2cras_pkg::PH_IDLE;
            unique case (phase)
                i2cras_pkg::PH_START, i2cras_pkg::PH_RSTART: begin
                    if (st == i2cras_pkg::ST_ARB_LOST) begin
                        res          = '0;
                        res.action   = i2cras_pkg::ACT_START;
                        phase_next   = i2cras_pkg::PH_START;
                    end else if (is_start) begin
                        res          = '0;
                        res.action   = i2cras_pkg::ACT_SEND;
                        res.tx_byte  = {ctx.device,
                                        (phase == i2cras_pkg::PH_RSTART)};
                        phase_next   = (phase == i2cras_pkg::PH_RSTART) ?
                                       i2cras_pkg::PH_SLAR : i2cras_pkg::PH_SLAW;
                    end
                end
                i2cras_pkg::PH_SLAW: begin
                    if (st == i2cras_pkg::ST_SLAW_NACK || st == i2cras_pkg::ST_ARB_LOST) begin
                        res        = '0;
                        res.action = i2cras_pkg::ACT_START;
                        phase_next = i2cras_pkg::PH_START;
                    end else if (st == i2cras_pkg::ST_SLAW_ACK) begin
                        res         = '0;
                        res.action  = i2cras_pkg::ACT_SEND;
                        res.tx_byte = ctx.register;
                        phase_next  = i2cras_pkg::PH_REG;
                    end
                end
                i2cras_pkg::PH_REG: begin
                    if (st == i2cras_pkg::ST_WDATA_ACK) begin
                        res = '0;
                        if (ctx.op_read) begin
                            res.action = i2cras_pkg::ACT_START;
                            phase_next = i2cras_pkg::PH_RSTART;
                        end else begin
                            res.action  = i2cras_pkg::ACT_SEND;
                            res.tx_byte = ctx.wdata;
                            phase_next  = i2cras_pkg::PH_DATA;
                        end
                    end
                end
                i2cras_pkg::PH_DATA: begin
                    res.success = (st == i2cras_pkg::ST_WDATA_ACK);
                end
                i2cras_pkg::PH_SLAR: begin
                    if (st == i2cras_pkg::ST_SLAR_NACK || st == i2cras_pkg::ST_ARB_LOST) begin
                        res        = '0;
                        res.action = i2cras_pkg::ACT_START;
                        phase_next = i2cras_pkg::PH_START;
                    end else if (st == i2cras_pkg::ST_SLAR_ACK) begin
                        res        = '0;
                        res.action = i2cras_pkg::ACT_RECV;
                        phase_next = i2cras_pkg::PH_RX;
                    end
                end
                i2cras_pkg::PH_RX: begin
                    if (st == i2cras_pkg::ST_RDATA_NACK) begin
                        res.success   = 1'b1;
                        res.read_data = req.rx_byte;
                    end
                end
                default: begin
                    // Idle never reaches here; busy excludes it.
                    res_valid  = 1'b0;
                    res        = '0;
                    phase_next = phase;
                end
            endcase
        end
    end

endmodule

// File: design/i2c_register_access_sequencer_top.sv
// Top level of the I2C register access sequencer.
// Input register, decode stage (i2cras_decode) and result register.
// Depends on i2cras_pkg and i2cras_decode.

// This block drives a byte-level I2C engine through one single-register
// access at a time. A command request starts a register write (start,
// address+W, register byte, data byte, stop) or a register read (start,
// address+W, register byte, repeated start, address+R, one byte received
// with NACK, stop). Each status request carries the engine's status code
// for the last action, and the block answers with the next action. Lost
// arbitration at a start or address byte, or a NACK of either address
// byte, restarts the transfer from its first start, with no retry limit;
// any other unexpected status ends the transfer with a stop flagged as
// failed. The final stop carries done_res, the success flag and, after a
// good read, the byte read. Commands sent during a transfer and status
// sent while idle are dropped without a result. The block takes one
// request per clock cycle while results are taken: a request waits in
// the input register, is decoded against the sequencer state in a single
// combinational pass, and its result, if any, appears in the result
// register on the next cycle. The sequencer state advances as each
// request leaves the input register, so consecutive requests see each
// other's effect with no gap. A stalled result holds the input side only
// once the input register is also full. There is no clearing pass after
// reset.
module i2c_register_access_sequencer_top (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  i2cras_pkg::in_t   s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output i2cras_pkg::out_t  m_data
);

    // Input register.
    logic               in_valid_reg;
    logic               in_valid_next;
    i2cras_pkg::in_t    in_data_reg;

    // Sequencer state.
    i2cras_pkg::phase_t phase_reg;
    i2cras_pkg::phase_t phase_next;
    i2cras_pkg::ctx_t   ctx_reg;
    i2cras_pkg::ctx_t   ctx_next;

    // Result register.
    logic               out_valid_reg;
    logic               out_valid_next;
    i2cras_pkg::out_t   out_data_reg;

    logic               res_valid;
    i2cras_pkg::out_t   res;
    logic               advance;

    // The request in the input register is decoded when the result slot
    // is empty or is being emptied in this cycle.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    i2cras_decode u_decode (
        .phase      (phase_reg),
        .ctx        (ctx_reg),
        .req        (in_data_reg),
        .res_valid  (res_valid),
        .res        (res),
        .phase_next (phase_next),
        .ctx_next   (ctx_next)
    );

    always_comb begin
        in_valid_next = s_ready ? s_valid : in_valid_reg;
        if (advance) begin
            out_valid_next = res_valid;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= i2cras_pkg::PH_IDLE;
            ctx_reg       <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) begin
                phase_reg <= phase_next;
                ctx_reg   <= ctx_next;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (advance && res_valid) begin
            out_data_reg <= res;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    // A result carries done_res exactly when it is a stop.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.done_res == (m_data.action == i2cras_pkg::ACT_STOP)))
        else $error("done_res does not match a stop action");

    // Success and read data only travel with the final stop.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.done_res) |-> (!m_data.success && m_data.read_data == 8'h00))
        else $error("success or read data outside a final stop");

    // A stop always returns the sequencer to idle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && res_valid && res.action == i2cras_pkg::ACT_STOP)
        |=> (phase_reg == i2cras_pkg::PH_IDLE))
        else $error("stop issued without returning to idle");

    // A command decoded while idle yields a start in the result register.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_data_reg.func == i2cras_pkg::FUNC_COMMAND
         && phase_reg == i2cras_pkg::PH_IDLE)
        |=> (m_valid && m_data.action == i2cras_pkg::ACT_START
             && phase_reg == i2cras_pkg::PH_START))
        else $error("idle command did not start a transfer");

    // Only a send action carries a byte for the bus.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.action != i2cras_pkg::ACT_SEND) |-> (m_data.tx_byte == 8'h00))
        else $error("tx_byte set on a non-send action");

endmodule
